[sv/svdq_pkg.sv]
// ----------------------------------------------------------------------------
// svdq_pkg
// shared types, codes and widths of the service deque
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svdq_pkg;

  localparam int DEF_CAPACITY = 64;

  localparam int KIND_W   = 3;
  localparam int ID_W     = 16;
  localparam int TIME_W   = 16;
  localparam int SUM_W    = 22;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_REMOVE_ID  = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHIFT,
    S_PEEK_RD,
    S_PEEK_CAP,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_op;
    logic exec;
    logic search_step;
    logic shift_step;
    logic remove_done;
    logic peek_rd;
    logic peek_cap;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  empty;
    logic  match;
    logic  search_end;
    logic  shift_done;
    logic  out_free;
  } stat_t;

endpackage

`default_nettype wire

[sv/svdq_ram.sv]
// ----------------------------------------------------------------------------
// svdq_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/svdq_dp.sv]
// ----------------------------------------------------------------------------
// svdq_dp
// deque datapath: pointers, running sum, entry store, search and gap closing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svdq_dp #(
  parameter int CAPACITY = svdq_pkg::DEF_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  input  svdq_pkg::cmd_t                 cmd,
  output svdq_pkg::stat_t                stat,
  input  logic [svdq_pkg::KIND_W-1:0]    kind,
  input  logic [svdq_pkg::ID_W-1:0]      entry_id,
  input  logic [svdq_pkg::TIME_W-1:0]    service_time,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [svdq_pkg::STATUS_W-1:0]  status,
  output logic [svdq_pkg::ID_W-1:0]      removed_id,
  output logic [svdq_pkg::TIME_W-1:0]    removed_time,
  output logic [svdq_pkg::COUNT_W-1:0]   entry_count,
  output logic                           front_valid,
  output logic [svdq_pkg::ID_W-1:0]      front_id,
  output logic [svdq_pkg::SUM_W-1:0]     total_time
);

  import svdq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 1;
  localparam int DW = ID_W + TIME_W;
  localparam logic [XW-1:0] CAP_X    = XW'(CAPACITY);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

  // queue state
  logic [AW-1:0]    head;
  logic [CW-1:0]    count;
  logic [SUM_W-1:0] tsum;

  // operation in hand
  logic [KIND_W-1:0] op_kind;
  logic [ID_W-1:0]   op_id;
  logic [TIME_W-1:0] op_time;
  status_t           res_status;
  logic [ID_W-1:0]   res_id;
  logic [TIME_W-1:0] res_time;
  logic [ID_W-1:0]   front_id_q;
  logic [TIME_W-1:0] front_time_q;

  // read pipeline for search and gap closing
  logic [CW-1:0] rd_off;
  logic          pend;
  logic [CW-1:0] pend_off;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic              full;
  logic              empty;
  logic              issue;
  logic              match;
  logic [ID_W-1:0]   rd_id;
  logic [TIME_W-1:0] rd_time;
  logic [AW-1:0]     head_dec;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     tail_slot;
  logic [CW-1:0]     last_off;
  logic              out_free;
  logic [CW+COUNT_W-1:0] cnt_ext;

  // circular slot of a logical offset from the front
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [XW-1:0] sum;
    sum = XW'(base) + {1'b0, off};
    if (sum >= CAP_X) begin
      sum = sum - CAP_X;
    end
    return sum[AW-1:0];
  endfunction

  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign rd_id     = ram_rdata[DW-1:TIME_W];
  assign rd_time   = ram_rdata[TIME_W-1:0];
  assign issue     = (rd_off < count);
  assign match     = pend && (rd_id == op_id);
  assign last_off  = count - 1'b1;
  assign head_dec  = (head == '0) ? LAST_SLOT : head - 1'b1;
  assign head_inc  = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_slot = slot_of(head, count);
  assign out_free  = !result_valid || !result_stall;
  assign cnt_ext   = {{COUNT_W{1'b0}}, count};

  assign stat.kind       = kind_t'(op_kind);
  assign stat.full       = full;
  assign stat.empty      = empty;
  assign stat.match      = match;
  assign stat.search_end = pend && !match && (pend_off == last_off);
  assign stat.shift_done = !pend && !issue;
  assign stat.out_free   = out_free;

  assign ram_raddr = cmd.peek_rd ? head : slot_of(head, rd_off);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_slot;
    ram_wdata = {op_id, op_time};
    if (cmd.exec && !full && (op_kind == KIND_PUSH_BACK)) begin
      ram_we = 1'b1;
    end else if (cmd.exec && !full && (op_kind == KIND_PUSH_FRONT)) begin
      ram_we    = 1'b1;
      ram_waddr = head_dec;
    end else if (cmd.shift_step && pend) begin
      // entry moves one place toward the front
      ram_we    = 1'b1;
      ram_waddr = slot_of(head, pend_off - 1'b1);
      ram_wdata = ram_rdata;
    end
  end

  svdq_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // queue state and read pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      tsum   <= '0;
      rd_off <= '0;
      pend   <= 1'b0;
    end else begin
      if (cmd.exec) begin
        unique case (kind_t'(op_kind))
          KIND_PUSH_BACK: begin
            if (!full) begin
              count <= count + 1'b1;
              tsum  <= tsum + SUM_W'(op_time);
            end
          end
          KIND_PUSH_FRONT: begin
            if (!full) begin
              head  <= head_dec;
              count <= count + 1'b1;
              tsum  <= tsum + SUM_W'(op_time);
            end
          end
          KIND_POP_FRONT: begin
            if (!empty) begin
              head  <= head_inc;
              count <= count - 1'b1;
              tsum  <= tsum - SUM_W'(front_time_q);
            end
          end
          KIND_REMOVE_ID: begin
            rd_off <= '0;
            pend   <= 1'b0;
          end
          KIND_CLEAR: begin
            head  <= '0;
            count <= '0;
            tsum  <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.search_step && match) begin
        tsum   <= tsum - SUM_W'(rd_time);
        rd_off <= pend_off + 1'b1;
        pend   <= 1'b0;
      end else if (cmd.search_step || cmd.shift_step) begin
        if (issue) begin
          rd_off <= rd_off + 1'b1;
          pend   <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      if (cmd.remove_done) begin
        count <= count - 1'b1;
      end
    end
  end

  // operation payload, result fields and cached front entry
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_kind    <= kind;
      op_id      <= entry_id;
      op_time    <= service_time;
      res_status <= ST_OK;
      res_id     <= '0;
      res_time   <= '0;
    end
    if (cmd.exec) begin
      unique case (kind_t'(op_kind))
        KIND_PUSH_BACK: begin
          if (full) begin
            res_status <= ST_FULL;
          end else if (empty) begin
            front_id_q   <= op_id;
            front_time_q <= op_time;
          end
        end
        KIND_PUSH_FRONT: begin
          if (full) begin
            res_status <= ST_FULL;
          end else begin
            front_id_q   <= op_id;
            front_time_q <= op_time;
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            res_status <= ST_MISS;
          end else begin
            res_id   <= front_id_q;
            res_time <= front_time_q;
          end
        end
        KIND_REMOVE_ID: begin
          res_status <= ST_MISS;
        end
        KIND_CLEAR: begin
        end
        default: begin
        end
      endcase
    end
    if (cmd.search_step && match) begin
      res_status <= ST_OK;
      res_id     <= rd_id;
      res_time   <= rd_time;
    end else if ((cmd.search_step || cmd.shift_step) && issue) begin
      pend_off <= rd_off;
    end
    if (cmd.peek_cap) begin
      front_id_q   <= rd_id;
      front_time_q <= rd_time;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= res_status;
      removed_id   <= res_id;
      removed_time <= res_time;
      entry_count  <= cnt_ext[COUNT_W-1:0];
      front_valid  <= !empty;
      front_id     <= empty ? '0 : front_id_q;
      total_time   <= tsum;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_full_push_holds : assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && full &&
     (op_kind == KIND_PUSH_BACK || op_kind == KIND_PUSH_FRONT))
    |=> (count == $past(count)) && (head == $past(head)))
    else $error("push onto full queue changed state");

  a_remove_dec : assert property (@(posedge clk) disable iff (rst)
    cmd.remove_done |=> (count == $past(count) - 1'b1))
    else $error("remove did not drop occupancy by one");

endmodule

`default_nettype wire

[sv/svdq_ctrl.sv]
// ----------------------------------------------------------------------------
// svdq_ctrl
// deque sequencer: execute, search, gap closing, front reload, result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svdq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  svdq_pkg::stat_t stat,
  output svdq_pkg::cmd_t  cmd
);

  import svdq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.kind)
          KIND_POP_FRONT: state_next = stat.empty ? S_FINISH : S_PEEK_RD;
          KIND_REMOVE_ID: state_next = stat.empty ? S_FINISH : S_SEARCH;
          default:        state_next = S_FINISH;
        endcase
      end
      S_SEARCH: begin
        priority if (stat.match) begin
          state_next = S_SHIFT;
        end else if (stat.search_end) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_next = S_PEEK_RD;
        end
      end
      S_PEEK_RD:  state_next = S_PEEK_CAP;
      S_PEEK_CAP: state_next = S_FINISH;
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    item_stall      = (state != S_IDLE);
    cmd.load_op     = (state == S_IDLE) && item_valid;
    cmd.exec        = (state == S_EXEC);
    cmd.search_step = (state == S_SEARCH);
    cmd.shift_step  = (state == S_SHIFT) && !stat.shift_done;
    cmd.remove_done = (state == S_SHIFT) && stat.shift_done;
    cmd.peek_rd     = (state == S_PEEK_RD);
    cmd.peek_cap    = (state == S_PEEK_CAP);
    cmd.load_out    = (state == S_FINISH) && stat.out_free;
  end

endmodule

`default_nettype wire

[sv/service_deque_with_remove_by_id_top.sv]
// ----------------------------------------------------------------------------
// service_deque_with_remove_by_id_top
// ordered service queue with push/pop at both ends and remove by ticket id
// ----------------------------------------------------------------------------
// Holds up to CAPACITY (id, service time) entries in a circular store kept in
// one ram. Each input transfer is one operation (push back, push front, pop
// front, remove first matching id from the front, clear) and gives exactly
// one result transfer with status, removed entry, count, front id and the
// running 22-bit total of service times. One operation is in work at a time;
// item_stall is low only while the sequencer is idle, and the next item is
// taken while a finished result still waits in the output register. A pop
// reads the new front back from the store. Remove by id is set by the
// single ram read port: the search reads one entry a cycle from the front,
// then the gap is closed by moving each later entry one place forward,
// again one a cycle.
// Store contents have no reset; stale front reads are masked while empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module service_deque_with_remove_by_id_top #(
  parameter int CAPACITY = svdq_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  // operation channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [svdq_pkg::KIND_W-1:0]   kind,
  input  logic [svdq_pkg::ID_W-1:0]     entry_id,
  input  logic [svdq_pkg::TIME_W-1:0]   service_time,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [svdq_pkg::STATUS_W-1:0] status,
  output logic [svdq_pkg::ID_W-1:0]     removed_id,
  output logic [svdq_pkg::TIME_W-1:0]   removed_time,
  output logic [svdq_pkg::COUNT_W-1:0]  entry_count,
  output logic                          front_valid,
  output logic [svdq_pkg::ID_W-1:0]     front_id,
  output logic [svdq_pkg::SUM_W-1:0]    total_time
);

  import svdq_pkg::*;

  // sequencer commands and datapath flags
  cmd_t  cmd;
  stat_t stat;

  // controller: accepts one transfer, then steps the datapath through the
  // operation and hands the result to the output register
  svdq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: head pointer, occupancy, total, entry ram and result register
  svdq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .entry_id     (entry_id),
    .service_time (service_time),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .removed_id   (removed_id),
    .removed_time (removed_time),
    .entry_count  (entry_count),
    .front_valid  (front_valid),
    .front_id     (front_id),
    .total_time   (total_time)
  );

endmodule

`default_nettype wire
